/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is held.
`define Y2R_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("y2r assertion failed");

// Same-cycle implication built on the check above.
`define Y2R_ASSERT_IMPLY(lbl, ante, cons) \
    `Y2R_ASSERT(lbl, (ante) |-> (cons))

`endif

/* rtl/y2r_pkg.sv */
package y2r_pkg;

    // Counter limits.
    localparam int MAX_LINE_PAIRS = 2048;
    localparam int MAX_LINES      = 4096;
    localparam int COL_W = (MAX_LINE_PAIRS > 1) ? $clog2(MAX_LINE_PAIRS) : 1;
    localparam int ROW_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

    // Register field widths and the configuration port.
    localparam int LINE_PAIRS_W  = 12;
    localparam int FRAME_LINES_W = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_PAIRS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LINES  = 2'd2;

    localparam logic [LINE_PAIRS_W-1:0]  RST_LINE_PAIRS  = 12'd320;
    localparam logic [FRAME_LINES_W-1:0] RST_FRAME_LINES = 13'd240;

    localparam logic FMT_BGR24  = 1'b0;
    localparam logic FMT_RGB565 = 1'b1;

    // Conversion arithmetic.
    localparam int SAMPLE_W = 8;
    localparam int PIXEL_W  = 24;
    localparam int SUM_W    = 20;

    localparam logic signed [SUM_W-1:0] K_Y       = 20'sd298;
    localparam logic signed [SUM_W-1:0] K_R_V     = 20'sd409;
    localparam logic signed [SUM_W-1:0] K_G_U     = 20'sd100;
    localparam logic signed [SUM_W-1:0] K_G_V     = 20'sd208;
    localparam logic signed [SUM_W-1:0] K_B_U     = 20'sd516;
    localparam logic signed [SUM_W-1:0] K_ROUND   = 20'sd128;
    localparam logic signed [SUM_W-1:0] Y_OFFSET  = 20'sd16;
    localparam logic signed [SUM_W-1:0] UV_OFFSET = 20'sd128;

    typedef struct packed {
        logic [LINE_PAIRS_W-1:0]  line_pairs;
        logic [FRAME_LINES_W-1:0] frame_lines;
    } t_frame_cfg;

    typedef struct packed {
        logic end_of_line;
        logic end_of_frame;
    } t_pos_flags;

    typedef struct packed {
        logic [PIXEL_W-1:0] first_pixel;
        logic [PIXEL_W-1:0] second_pixel;
        t_pos_flags         flags;
    } t_result;

endpackage

/* rtl/y2r_lane.sv */
module y2r_lane
    import y2r_pkg::*;
(
    input  logic                i_pixel_format,
    input  logic [SAMPLE_W-1:0] i_luma,
    input  logic [SAMPLE_W-1:0] i_chroma_blue,
    input  logic [SAMPLE_W-1:0] i_chroma_red,
    output logic [PIXEL_W-1:0]  o_pixel
);

    // Floor shift by 8 and limit to 0..255.
    function automatic logic [7:0] shift_clip(input logic signed [SUM_W-1:0] v);
        logic [7:0] res;
        if (v[SUM_W-1]) begin
            res = 8'd0;
        end else if (|v[SUM_W-2:16]) begin
            res = 8'hFF;
        end else begin
            res = v[15:8];
        end
        return res;
    endfunction

    logic signed [SUM_W-1:0] c_term;
    logic signed [SUM_W-1:0] d_term;
    logic signed [SUM_W-1:0] e_term;
    logic signed [SUM_W-1:0] sum_r;
    logic signed [SUM_W-1:0] sum_g;
    logic signed [SUM_W-1:0] sum_b;
    logic [7:0]              red;
    logic [7:0]              green;
    logic [7:0]              blue;

    assign c_term = $signed({{(SUM_W-SAMPLE_W){1'b0}}, i_luma}) - Y_OFFSET;
    assign d_term = $signed({{(SUM_W-SAMPLE_W){1'b0}}, i_chroma_blue}) - UV_OFFSET;
    assign e_term = $signed({{(SUM_W-SAMPLE_W){1'b0}}, i_chroma_red}) - UV_OFFSET;

    assign sum_r = c_term * K_Y + e_term * K_R_V + K_ROUND;
    assign sum_g = c_term * K_Y - d_term * K_G_U - e_term * K_G_V + K_ROUND;
    assign sum_b = c_term * K_Y + d_term * K_B_U + K_ROUND;

    assign red   = shift_clip(sum_r);
    assign green = shift_clip(sum_g);
    assign blue  = shift_clip(sum_b);

    always_comb begin
        if (i_pixel_format == FMT_RGB565) begin
            o_pixel = {8'd0, red[7:3], green[7:2], blue[7:3]};
        end else begin
            o_pixel = {red, green, blue};
        end
    end

endmodule

/* rtl/y2r_position.sv */
module y2r_position
    import y2r_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  t_frame_cfg i_cfg,
    output t_pos_flags o_flags
);

    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic [31:0]      pairs_wide;
    logic [31:0]      lines_wide;

    assign pairs_wide = {{(32-LINE_PAIRS_W){1'b0}}, i_cfg.line_pairs};
    assign lines_wide = {{(32-FRAME_LINES_W){1'b0}}, i_cfg.frame_lines};

    // A length of zero counts as one, and a length above the limit as the limit.
    always_comb begin
        if (pairs_wide == 32'd0) begin
            last_col = '0;
        end else if (pairs_wide > 32'(MAX_LINE_PAIRS)) begin
            last_col = COL_W'(MAX_LINE_PAIRS - 1);
        end else begin
            last_col = COL_W'(pairs_wide - 32'd1);
        end
        if (lines_wide == 32'd0) begin
            last_row = '0;
        end else if (lines_wide > 32'(MAX_LINES)) begin
            last_row = ROW_W'(MAX_LINES - 1);
        end else begin
            last_row = ROW_W'(lines_wide - 32'd1);
        end
    end

    assign o_flags.end_of_line  = (r_col >= last_col);
    assign o_flags.end_of_frame = o_flags.end_of_line && (r_row >= last_row);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (o_flags.end_of_line) begin
                n_col = '0;
                n_row = o_flags.end_of_frame ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

/* rtl/yuv420_to_rgb_pixel_converter.sv */
// One beat carries two neighboring luma samples and their shared chroma pair;
// the block returns both pixels converted with the BT.601 limited-range integer
// formula, packed as 24-bit B,G,R (B in the low byte) or as RGB565 in the low
// 16 bits, plus end-of-line and end-of-frame flags from its column and line
// counters. It takes one beat per cycle: two lanes convert the pixels in parallel
// straight into the output register, and a second, skid register holds a result
// when the sink stalls, so input ready only drops while that skid entry is full.
// Configuration writes take effect on the next beat and do not move the counters.
`include "assert_macros.svh"

module yuv420_to_rgb_pixel_converter
    import y2r_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Input channel.
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_W-1:0]    i_luma_first,
    input  logic [SAMPLE_W-1:0]    i_luma_second,
    input  logic [SAMPLE_W-1:0]    i_chroma_blue,
    input  logic [SAMPLE_W-1:0]    i_chroma_red,
    // Output channel.
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [PIXEL_W-1:0]     o_first_pixel,
    output logic [PIXEL_W-1:0]     o_second_pixel,
    output logic                   o_end_of_line,
    output logic                   o_end_of_frame
);

    // Configuration registers.
    logic                     r_pixel_format;
    t_frame_cfg               r_frame_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format          <= FMT_BGR24;
            r_frame_cfg.line_pairs  <= RST_LINE_PAIRS;
            r_frame_cfg.frame_lines <= RST_FRAME_LINES;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PIXEL_FORMAT:  r_pixel_format <= i_cfg_data[0];
                CFG_LINE_PAIRS:    r_frame_cfg.line_pairs <= i_cfg_data[LINE_PAIRS_W-1:0];
                CFG_FRAME_LINES:   r_frame_cfg.frame_lines <= i_cfg_data[FRAME_LINES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic               in_accept;
    logic               out_pop;
    t_pos_flags         pos_flags;
    logic [PIXEL_W-1:0] lane_first_pixel;
    logic [PIXEL_W-1:0] lane_second_pixel;
    t_result            new_result;

    // The counters advance on every accepted beat and report where this beat sits.
    y2r_position u_position (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (in_accept),
        .i_cfg     (r_frame_cfg),
        .o_flags   (pos_flags)
    );

    // Two conversion lanes, one per pixel, sharing the chroma samples.
    y2r_lane u_lane_first (
        .i_pixel_format (r_pixel_format),
        .i_luma         (i_luma_first),
        .i_chroma_blue  (i_chroma_blue),
        .i_chroma_red   (i_chroma_red),
        .o_pixel        (lane_first_pixel)
    );

    y2r_lane u_lane_second (
        .i_pixel_format (r_pixel_format),
        .i_luma         (i_luma_second),
        .i_chroma_blue  (i_chroma_blue),
        .i_chroma_red   (i_chroma_red),
        .o_pixel        (lane_second_pixel)
    );

    // Merge the lane pixels with the position flags into one result.
    assign new_result = {lane_first_pixel, lane_second_pixel, pos_flags};

    // Output register with a single skid entry behind it. New beats go to the
    // output register when it is free or draining this cycle, otherwise to the
    // skid entry; the skid entry moves forward as soon as the sink takes a beat.
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    assign o_in_ready = !r_skid_valid;
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_pop    = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= new_result;
            end
        end else if (in_accept) begin
            if (r_out_valid) begin
                r_skid <= new_result;
            end else begin
                r_out <= new_result;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_first_pixel  = r_out.first_pixel;
    assign o_second_pixel = r_out.second_pixel;
    assign o_end_of_line  = r_out.flags.end_of_line;
    assign o_end_of_frame = r_out.flags.end_of_frame;

    // The skid entry is only ever occupied behind a full output register.
    `Y2R_ASSERT_IMPLY(a_skid_behind_out, r_skid_valid, r_out_valid)
    // The skid entry fills only when the output register was stalled.
    `Y2R_ASSERT(a_skid_on_stall, $rose(r_skid_valid) |-> $past(r_out_valid && !i_out_ready))
    // The last pair of a frame is always the last pair of its line.
    `Y2R_ASSERT_IMPLY(a_eof_has_eol, r_out_valid && o_end_of_frame, o_end_of_line)

endmodule
